>>> hw/rtl/rmf_pkg.sv
// Shared types and constants for the RGB 3x3 median filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package rmf_pkg;

  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_COMPONENT_BITS = 8;
  localparam int CFG_BITS           = 11;
  localparam int HEIGHT_BITS        = 11;
  localparam int HEIGHT_LIMIT       = 1024;
  localparam int ADDR_BITS          = 3;
  localparam int DATA_BITS          = 32;
  localparam int RESET_WIDTH        = 640;
  localparam int RESET_HEIGHT       = 480;
  localparam int QUEUE_DEPTH        = 4;
  localparam int WINDOW_CELLS       = 9;
  localparam int RANK_BITS          = 4;
  localparam int HALF_BITS          = 3;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  // neighbourhood edges and frame end for one queued window
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } rmf_flags_t;

endpackage
`default_nettype wire

>>> hw/rtl/rmf_front.sv
// Front end: accepts items, tracks frame position, line stores and window.
// Pushes one window with edge flags per result into the queue. Uses rmf_pkg.
`default_nettype none
module rmf_front #(
  parameter int MAX_WIDTH      = rmf_pkg::DEF_MAX_WIDTH,
  parameter int COMPONENT_BITS = rmf_pkg::DEF_COMPONENT_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      restart,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]            image_width,
  input  wire logic [rmf_pkg::HEIGHT_BITS-1:0]           image_height,
  input  wire logic                                      in_valid,
  output logic                                           in_stall,
  input  wire logic                                      req_type,
  input  wire logic [COMPONENT_BITS-1:0]                 red_in,
  input  wire logic [COMPONENT_BITS-1:0]                 green_in,
  input  wire logic [COMPONENT_BITS-1:0]                 blue_in,
  input  wire logic                                      q_full,
  output logic                                           push,
  output logic [3*COMPONENT_BITS-1:0]                    push_cells [rmf_pkg::WINDOW_CELLS],
  output rmf_pkg::rmf_flags_t                            push_flags
);
  import rmf_pkg::*;

  localparam int PW = 3 * COMPONENT_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // frame position and result position
  logic [WW-1:0]          col;
  logic [HEIGHT_BITS-1:0] row;
  logic [WW-1:0]          ec;
  logic [HEIGHT_BITS-1:0] er;

  // stage 1: item waiting for line store data
  logic                   s1_valid;
  logic [PW-1:0]          s1_px;
  logic [CW-1:0]          s1_col;
  logic                   s1_emit;
  logic                   s1_restart;
  rmf_flags_t             s1_flags;
  logic [2*PW-1:0]        rd_line;
  logic [2*PW-1:0]        wr_line;
  logic                   s1_go;

  logic [2*PW-1:0]        line_mem [MAX_WIDTH];
  logic [PW-1:0]          win [3][3];
  logic [PW-1:0]          new_col [3];

  logic                   accept;
  logic                   in_frame;
  logic                   ignore;
  logic                   emit_now;
  logic                   last_now;
  logic                   col_wrap;
  logic                   ec_wrap;

  // classify the incoming item
  always_comb begin
    in_frame = row < image_height;
    ignore   = in_frame && req_type;
    emit_now = (row >= HEIGHT_BITS'(2)) || ((row == HEIGHT_BITS'(1)) && (col != '0));
    last_now = (er == image_height - HEIGHT_BITS'(1)) && (ec == image_width - WW'(1));
    col_wrap = (col + WW'(1)) >= image_width;
    ec_wrap  = (ec + WW'(1)) >= image_width;
  end

  assign s1_go    = s1_valid && (!s1_emit || !q_full);
  assign in_stall = s1_valid && !s1_go;
  assign accept   = in_valid && !in_stall;
  assign wr_line  = {rd_line[PW-1:0], s1_px};

  // position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
      ec  <= '0;
      er  <= '0;
    end else if (accept && !ignore) begin
      if (emit_now && last_now) begin
        col <= '0;
        row <= '0;
        ec  <= '0;
        er  <= '0;
      end else begin
        if (col_wrap) begin
          col <= '0;
          row <= row + HEIGHT_BITS'(1);
        end else begin
          col <= col + WW'(1);
        end
        if (emit_now) begin
          if (ec_wrap) begin
            ec <= '0;
            er <= er + HEIGHT_BITS'(1);
          end else begin
            ec <= ec + WW'(1);
          end
        end
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= !ignore;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px             <= in_frame ? {blue_in, green_in, red_in} : '0;
      s1_col            <= col[CW-1:0];
      s1_emit           <= emit_now;
      s1_restart        <= emit_now && last_now;
      s1_flags.top_ok   <= er != '0;
      s1_flags.bot_ok   <= (er + HEIGHT_BITS'(1)) < image_height;
      s1_flags.left_ok  <= ec != '0;
      s1_flags.right_ok <= !ec_wrap;
      s1_flags.last     <= last_now;
    end
  end

  // line stores: entry holds {upper, lower}; forward a write to the same column
  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_col] <= wr_line;
    end
    if (accept) begin
      if (s1_go && (s1_col == col[CW-1:0])) begin
        rd_line <= wr_line;
      end else begin
        rd_line <= line_mem[col[CW-1:0]];
      end
    end
  end

  assign new_col[0] = rd_line[2*PW-1:PW];
  assign new_col[1] = rd_line[PW-1:0];
  assign new_col[2] = s1_px;

  // window shift, cleared at frame restart
  always_ff @(posedge clk) begin
    if (rst || restart || (s1_go && s1_restart)) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win[c][r] <= '0;
        end
      end
    end else if (s1_go) begin
      for (int r = 0; r < 3; r++) begin
        win[0][r] <= win[1][r];
        win[1][r] <= win[2][r];
        win[2][r] <= new_col[r];
      end
    end
  end

  // window around the result pixel: left, centre, right columns
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      push_cells[r]     = win[1][r];
      push_cells[3 + r] = win[2][r];
      push_cells[6 + r] = new_col[r];
    end
  end

  assign push       = s1_go && s1_emit;
  assign push_flags = s1_flags;

endmodule
`default_nettype wire

>>> hw/rtl/rmf_queue.sv
// Short first-in first-out queue between front and back end.
// Generic width; uses rmf_pkg for the default depth.
`default_nettype none
module rmf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rmf_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data,
  output logic                  not_empty,
  output logic                  full
);
  import rmf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    head;
  logic [AW-1:0]    tail;
  logic [NW-1:0]    count;

  assign not_empty = count != '0;
  assign full      = count == NW'(DEPTH);
  assign head_data = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + AW'(1);
      end
      if (pop) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rmf_median.sv
// Back end: masks the window, ranks each channel, selects the median.
// Three stages under one stall enable, output register last. Uses rmf_pkg.
`default_nettype none
module rmf_median #(
  parameter int COMPONENT_BITS = rmf_pkg::DEF_COMPONENT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire logic [3*COMPONENT_BITS-1:0]   q_cells [rmf_pkg::WINDOW_CELLS],
  input  wire rmf_pkg::rmf_flags_t           q_flags,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [COMPONENT_BITS-1:0]          red_out,
  output logic [COMPONENT_BITS-1:0]          green_out,
  output logic [COMPONENT_BITS-1:0]          blue_out,
  output logic                               last_pixel
);
  import rmf_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int PW = 3 * CB;

  logic                   adv;
  logic [WINDOW_CELLS-1:0] in_ok;
  logic [RANK_BITS-1:0]   in_count;

  logic                   p1_valid;
  logic [PW-1:0]          p1_cells [WINDOW_CELLS];
  logic [WINDOW_CELLS-1:0] p1_ok;
  logic [HALF_BITS-1:0]   p1_half;
  logic                   p1_last;

  logic                   p2_valid;
  logic [PW-1:0]          p2_cells [WINDOW_CELLS];
  logic [WINDOW_CELLS-1:0] p2_ok;
  logic [HALF_BITS-1:0]   p2_half;
  logic                   p2_last;
  logic [RANK_BITS-1:0]   p2_rank [3][WINDOW_CELLS];

  logic [RANK_BITS-1:0]   rank [3][WINDOW_CELLS];
  logic [CB-1:0]          pick [3];

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  // cells inside the image, and how many
  always_comb begin
    in_count = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        in_ok[c*3 + r] = (c != 0 || q_flags.left_ok) && (c != 2 || q_flags.right_ok)
                       && (r != 0 || q_flags.top_ok) && (r != 2 || q_flags.bot_ok);
      end
    end
    for (int i = 0; i < WINDOW_CELLS; i++) begin
      in_count = in_count + RANK_BITS'(in_ok[i]);
    end
  end

  // rank of each cell among the valid ones, ties broken by position
  always_comb begin
    logic [CB-1:0] vi;
    logic [CB-1:0] vj;
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < WINDOW_CELLS; i++) begin
        rank[ch][i] = '0;
        vi = p1_cells[i][ch*CB +: CB];
        for (int j = 0; j < WINDOW_CELLS; j++) begin
          vj = p1_cells[j][ch*CB +: CB];
          if (j != i && p1_ok[j] && ((vj < vi) || ((vj == vi) && (j < i)))) begin
            rank[ch][i] = rank[ch][i] + RANK_BITS'(1);
          end
        end
      end
    end
  end

  // median is the valid cell whose rank is half the count
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pick[ch] = '0;
      for (int i = 0; i < WINDOW_CELLS; i++) begin
        if (p2_ok[i] && (p2_rank[ch][i] == RANK_BITS'(p2_half))) begin
          pick[ch] = pick[ch] | p2_cells[i][ch*CB +: CB];
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_valid  <= q_valid;
      p2_valid  <= p1_valid;
      out_valid <= p2_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_cells   <= q_cells;
      p1_ok      <= in_ok;
      p1_half    <= in_count[RANK_BITS-1:1];
      p1_last    <= q_flags.last;
      p2_cells   <= p1_cells;
      p2_ok      <= p1_ok;
      p2_half    <= p1_half;
      p2_last    <= p1_last;
      p2_rank    <= rank;
      red_out    <= pick[0];
      green_out  <= pick[1];
      blue_out   <= pick[2];
      last_pixel <= p2_last;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rgb_median_filter_3x3.sv
// RGB 3x3 median filter, top level: configuration registers, front end,
// queue and median back end. Uses rmf_pkg, rmf_front, rmf_queue, rmf_median.
//
// Usage: pixels of a frame enter in raster order on the input channel
// (in_valid / in_stall), one item per pixel with req_type low. Each pixel's
// filtered value appears on the output channel (out_valid / out_stall)
// once item width+1 of the stream has been taken; after the last pixel,
// width+1 drain items (req_type high) flush the rest. last_pixel marks the
// final result of a frame, after which the next item starts a new frame.
// The user must write width and height over the APB port only while idle;
// the block itself does not enforce it. A write restarts the frame.
// Throughput is one item per cycle while in_stall is low. The path from the
// item that releases a result to out_valid runs through line store read,
// queue, median masking, ranking and output register. Reset clears position
// counters, window and queue and loads 640 x 480; the line stores need no
// clearing. When the receiver stalls, the output register and back end hold;
// the 4-entry queue fills, and in_stall rises only once it is full.
`default_nettype none
module rgb_median_filter_3x3 #(
  parameter int MAX_WIDTH      = rmf_pkg::DEF_MAX_WIDTH,
  parameter int COMPONENT_BITS = rmf_pkg::DEF_COMPONENT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rmf_pkg::ADDR_BITS-1:0]     paddr,
  input  wire logic [rmf_pkg::DATA_BITS-1:0]     pwdata,
  output logic [rmf_pkg::DATA_BITS-1:0]          prdata,
  output logic                                   pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              req_type,
  input  wire logic [COMPONENT_BITS-1:0]         red_in,
  input  wire logic [COMPONENT_BITS-1:0]         green_in,
  input  wire logic [COMPONENT_BITS-1:0]         blue_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [COMPONENT_BITS-1:0]              red_out,
  output logic [COMPONENT_BITS-1:0]              green_out,
  output logic [COMPONENT_BITS-1:0]              blue_out,
  output logic                                   last_pixel
);
  import rmf_pkg::*;

  localparam int PW = 3 * COMPONENT_BITS;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int FB = $bits(rmf_flags_t);
  localparam int QW = WINDOW_CELLS * PW + FB;

  logic [WW-1:0]          image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic                   cfg_wr;
  logic [CFG_BITS-1:0]    cfg_val;
  reg_index_t             cfg_idx;

  logic                   push;
  logic [PW-1:0]          push_cells [WINDOW_CELLS];
  rmf_flags_t             push_flags;
  logic [QW-1:0]          push_data;
  logic [QW-1:0]          head_data;
  logic                   q_pop;
  logic                   q_not_empty;
  logic                   q_full;
  logic [PW-1:0]          q_cells [WINDOW_CELLS];
  rmf_flags_t             q_flags;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_val = pwdata[CFG_BITS-1:0];
  assign cfg_idx = reg_index_t'(paddr[2]);

  // configuration registers, clamped to their legal range
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WW'(RESET_WIDTH);
      image_height <= HEIGHT_BITS'(RESET_HEIGHT);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIDTH: begin
          if (cfg_val == '0) begin
            image_width <= WW'(1);
          end else if (32'(cfg_val) > 32'(MAX_WIDTH)) begin
            image_width <= WW'(MAX_WIDTH);
          end else begin
            image_width <= WW'(cfg_val);
          end
        end
        REG_HEIGHT: begin
          if (cfg_val == '0) begin
            image_height <= HEIGHT_BITS'(1);
          end else if (32'(cfg_val) > 32'(HEIGHT_LIMIT)) begin
            image_height <= HEIGHT_BITS'(HEIGHT_LIMIT);
          end else begin
            image_height <= cfg_val;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = DATA_BITS'(image_width);
      REG_HEIGHT: prdata = DATA_BITS'(image_height);
      default:    prdata = '0;
    endcase
  end

  rmf_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_wr),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .q_full       (q_full),
    .push         (push),
    .push_cells   (push_cells),
    .push_flags   (push_flags)
  );

  // pack and unpack queue entries
  always_comb begin
    push_data[FB-1:0] = push_flags;
    q_flags           = head_data[FB-1:0];
    for (int i = 0; i < WINDOW_CELLS; i++) begin
      push_data[FB + i*PW +: PW] = push_cells[i];
      q_cells[i]                 = head_data[FB + i*PW +: PW];
    end
  end

  rmf_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .head_data (head_data),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  rmf_median #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_median (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_cells    (q_cells),
    .q_flags    (q_flags),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .last_pixel (last_pixel)
  );

endmodule
`default_nettype wire

>>> hw/rtl/rmf_checker.sv
// Port-level checks for the RGB 3x3 median filter.
// Bound to rgb_median_filter_3x3; uses rmf_pkg for widths.
`default_nettype none
module rmf_checker #(
  parameter int COMPONENT_BITS = rmf_pkg::DEF_COMPONENT_BITS
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pready,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [COMPONENT_BITS-1:0]   red_out,
  input wire logic [COMPONENT_BITS-1:0]   green_out,
  input wire logic [COMPONENT_BITS-1:0]   blue_out,
  input wire logic                        last_pixel
);
  import rmf_pkg::*;

  // a stalled result stays on the port unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid
      && $stable({red_out, green_out, blue_out, last_pixel}))
    else $error("output item changed while stalled");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // register access never waits
  a_no_wait: assert property (@(posedge clk) disable iff (rst)
    psel && penable |-> pready)
    else $error("register access stalled");

endmodule

bind rgb_median_filter_3x3 rmf_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_rmf_checker (.*);
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for rgb_median_filter_3x3: streams RGB frames,
// predicts each 3x3 channel median in step and compares every result item.
// Depends on rmf_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_top;
  import rmf_pkg::*;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } median_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic last_pixel;

  // filter model state
  int unsigned img_w = RESET_WIDTH;
  int unsigned img_h = RESET_HEIGHT;
  logic [23:0] row_above [DEF_MAX_WIDTH];
  logic [23:0] row_prev  [DEF_MAX_WIDTH];
  logic [23:0] win [3][3];  // [column, 0 oldest][row, 0 top]
  int unsigned in_col, in_row, done_px;

  median_px_t medians_due[$];
  int  mismatches = 0;
  int  pixels_sent = 0;
  bit  no_idle = 1'b0;
  int  hold_left = 0;

  rgb_median_filter_3x3 uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .last_pixel(last_pixel)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void restart_frame();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    in_col = 0;
    in_row = 0;
    done_px = 0;
  endfunction

  function automatic void set_register(reg_index_t idx, logic [31:0] value);
    int unsigned v;
    v = value & 32'h7FF;
    if (v == 0) v = 1;
    if (v > DEF_MAX_WIDTH) v = DEF_MAX_WIDTH;  // both limits are 1024
    if (idx == REG_WIDTH) img_w = v;
    else img_h = v;
    restart_frame();
  endfunction

  // one channel: median of the neighbours that lie inside the image
  function automatic logic [7:0] channel_median(int ch, int mid, int unsigned rc,
                                                int unsigned cc);
    int vals [9];
    int n;
    int v;
    int j;
    n = 0;
    for (int di = -1; di <= 1; di++) begin
      if (di < 0 && rc == 0) continue;
      if (di > 0 && rc + 1 >= img_h) continue;
      for (int dj = -1; dj <= 1; dj++) begin
        if (dj < 0 && cc == 0) continue;
        if (dj > 0 && cc + 1 >= img_w) continue;
        if (mid + dj < 0 || mid + dj > 2) continue;
        vals[n] = int'(win[mid + dj][di + 1][ch*8 +: 8]);
        n++;
      end
    end
    if (n == 0) return '0;
    for (int i = 1; i < n; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    return 8'(vals[n/2]);
  endfunction

  function automatic void queue_median(int mid);
    median_px_t m;
    int unsigned rc, cc;
    rc = done_px / img_w;
    cc = done_px % img_w;
    m.red   = channel_median(0, mid, rc, cc);
    m.green = channel_median(1, mid, rc, cc);
    m.blue  = channel_median(2, mid, rc, cc);
    m.last  = (done_px + 1 == img_w * img_h);
    medians_due.push_back(m);
  endfunction

  // advance the model by one accepted item
  function automatic void predict_item(bit drain, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b);
    int unsigned total, pos, c;
    logic [23:0] px;
    bit made;
    total = img_w * img_h;
    pos = in_row * img_w + in_col;
    c = in_col;
    px = '0;
    made = 1'b0;
    if (pos < total) begin
      if (drain) return;  // early drain is ignored
      px = {b, g, r};
    end
    if (c == 0 && pos >= img_w + 1 && done_px < total) begin
      queue_median(2);
      made = 1'b1;
    end
    for (int j = 0; j < 3; j++) begin
      win[0][j] = win[1][j];
      win[1][j] = win[2][j];
    end
    win[2][0] = row_above[c];
    win[2][1] = row_prev[c];
    win[2][2] = px;
    row_above[c] = row_prev[c];
    row_prev[c] = px;
    if (c != 0 && pos >= img_w + 1 && done_px < total) begin
      queue_median(1);
      made = 1'b1;
    end
    in_col++;
    if (in_col >= img_w) begin
      in_col = 0;
      in_row++;
    end
    if (made) begin
      done_px++;
      if (done_px >= total) restart_frame();
    end
  endfunction

  // result side: check each accepted item, stall at random or on request
  initial begin
    median_px_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0b", $realtime,
                   red_out, green_out, blue_out, last_pixel);
          mismatches++;
        end else begin
          e = medians_due.pop_front();
          if (red_out !== e.red || green_out !== e.green || blue_out !== e.blue ||
              last_pixel !== e.last) begin
            $display("%0t: expected r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                     $realtime, e.red, e.green, e.blue, e.last,
                     red_out, green_out, blue_out, last_pixel);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 21);
      end
    end
  end

  function automatic logic [7:0] pick_component();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'h00;
    if (k == 1) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // offer one item and wait for it to be taken; valid is left high
  task automatic send_item(bit drain, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= drain;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(drain && in_row * img_w + in_col < img_w * img_h)) pixels_sent++;
    predict_item(drain, r, g, b);
  endtask

  task automatic send_random_pixel();
    send_item(1'b0, pick_component(), pick_component(), pick_component());
  endtask

  // lower valid and let every expected result come out, plus the latency
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (medians_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(reg_index_t idx, logic [31:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // read a register back and compare with the clamped value
  task automatic reg_check(reg_index_t idx, int unsigned want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== DATA_BITS'(want)) begin
      $display("%0t: register %0d expected %0d, got %0d", $realtime, idx, want, prdata);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_size(logic [31:0] w, logic [31:0] h);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // one frame: pixels then drains; noise adds early drains and late pixels
  task automatic send_frame(bit noise, bit cut_short);
    int unsigned n;
    n = img_w * img_h;
    for (int unsigned k = 0; k < n; k++) begin
      if (noise && $urandom_range(99) < 5) send_item(1'b1, pick_component(), 8'h00, 8'hFF);
      if (cut_short && k == n / 2) return;
      send_random_pixel();
    end
    for (int unsigned k = 0; k <= img_w; k++) begin
      if (noise && $urandom_range(99) < 30) send_random_pixel();
      else send_item(1'b1, 8'h00, 8'h00, 8'h00);
    end
  endtask

  // small frames with extreme values, early drain, late pixel, thin images
  task automatic test_directed();
    logic [7:0] vals [9] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h10};
    set_size(3, 3);
    for (int k = 0; k < 9; k++) begin
      if (k == 4) send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);
      send_item(1'b0, vals[k], vals[8-k], ~vals[k]);
    end
    send_item(1'b0, 8'hFF, 8'hFF, 8'hFF);  // late pixel taken as a drain
    repeat (3) send_item(1'b1, 8'h00, 8'h00, 8'h00);
    set_size(1, 1);
    send_frame(1'b0, 1'b0);
    set_size(1, 3);
    send_frame(1'b0, 1'b0);
    set_size(3, 1);
    send_frame(1'b0, 1'b0);
  endtask

  // register extremes: zero, above range, masked upper bits
  task automatic test_size_limits();
    set_size(0, 0);
    reg_check(REG_WIDTH, 1);
    reg_check(REG_HEIGHT, 1);
    send_frame(1'b0, 1'b0);
    set_size(32'h0000_07FF, 1);
    reg_check(REG_WIDTH, 1024);
    set_size(1, 32'h0000_0400);
    reg_check(REG_HEIGHT, 1024);
    set_size(32'hFFFF_F803, 32'hFFFF_FFFF);  // 3 wide, 1024 rows
    reg_check(REG_WIDTH, 3);
    reg_check(REG_HEIGHT, 1024);
    reg_write(REG_HEIGHT, 32'h0000_0002);
    send_frame(1'b0, 1'b0);
  endtask

  // a register write part way through a frame starts it afresh
  task automatic test_restart();
    set_size(5, 4);
    send_frame(1'b0, 1'b1);
    reg_write(REG_WIDTH, 4);
    send_frame(1'b0, 1'b0);
  endtask

  // long receiver hold while the sender keeps going, then a sender pause
  task automatic test_backpressure();
    set_size(6, 5);
    no_idle = 1'b1;
    hold_left = 200;
    send_frame(1'b0, 1'b0);
    no_idle = 1'b0;
    set_size(7, 4);
    for (int k = 0; k < 15; k++) send_random_pixel();
    wait_drained();
    for (int k = 15; k < 28; k++) send_random_pixel();
    for (int k = 0; k < 8; k++) send_item(1'b1, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random();
    int start;
    int w, h;
    start = pixels_sent;
    while (pixels_sent - start < 1600) begin
      no_idle = (pixels_sent - start > 600 && pixels_sent - start < 900);
      if ($urandom_range(19) == 0) w = $urandom_range(40, 70);
      else w = $urandom_range(1, 16);
      h = $urandom_range(1, 10);
      set_size(w, h);
      send_frame($urandom_range(99) < 20, $urandom_range(99) < 5);
      if ($urandom_range(3) == 0) send_frame(1'b0, 1'b0);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      row_above[i] = '0;
      row_prev[i] = '0;
    end
    restart_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_size_limits();
    test_restart();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_front.sv
hw/rtl/rmf_queue.sv
hw/rtl/rmf_median.sv
hw/rtl/rgb_median_filter_3x3.sv
hw/rtl/rmf_checker.sv
sim/tb_top.sv
